>>> src/plt_pkg.sv
// ---------------------------------------------------------------------------
// plt_pkg: shared definitions for the property line tokenizer
// Tag codes, stream field widths and the character constants the parser uses.
// ---------------------------------------------------------------------------
package plt_pkg;

    // Tag codes carried in the result kind field
    localparam int unsigned KIND_W = 3;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_NONE  = 3'd0;
    localparam t_kind KIND_KEY   = 3'd1;
    localparam t_kind KIND_VALUE = 3'd2;
    localparam t_kind KIND_PAIR  = 3'd3;
    localparam t_kind KIND_ERROR = 3'd4;

    // Input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // Characters with meaning to the parser
    localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Output tuser layout: kind, key_start, subkey from bit 0 up
    localparam int unsigned OUT_USER_W = KIND_W + 2;

    typedef struct packed {
        logic  subkey;
        logic  key_start;
        t_kind kind;
    } t_out_user;

endpackage

>>> src/property_line_tokenizer_top.sv
// ---------------------------------------------------------------------------
// property_line_tokenizer_top: byte tagger for key=value properties text
// Two-register pipeline: input beat register, tag/parse logic, result register.
// ---------------------------------------------------------------------------
// Takes one text byte per beat and tags it as a key byte, a value byte, the
// line end that closes a pair, structural (line ends, '=', comment text) or
// error. Lines end in LF or CR LF; lines starting with '#' are comments. A
// line that starts with '.' directly after a pair line is a subkey line and
// its bytes are flagged subkey. Stray CR, a '.' line not following a pair
// line, an empty subkey and a line break inside a key put the parser in an
// error state that tags every following byte as error until an end-of-stream
// beat (tuser bit 0 set). That beat always yields one result (pair end if a
// value was pending, error if in error, else none) and returns all parser
// state to its reset values. Throughput is one byte per clock while the
// downstream side takes results: the parser state is a 4-bit register
// updated by a single level of next-state logic as a beat moves from the
// input register into the result register, once the result slot frees.
// Both registers advance independently, so a new byte is taken while a
// finished result still waits for the downstream side.
// ---------------------------------------------------------------------------
module property_line_tokenizer_top
    import plt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] in_byte
    input  logic                  i_s_axis_tuser,   // [0] op (1 = end of stream)

    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] out_byte
    output logic [OUT_USER_W-1:0] o_m_axis_tuser    // [2:0] kind, [3] key_start, [4] subkey
);

    typedef enum logic [3:0] {
        S_START   = 4'd0,
        S_KEY     = 4'd1,
        S_SUBKEY  = 4'd2,
        S_EQUAL   = 4'd3,
        S_VALUE   = 4'd4,
        S_COMMENT = 4'd5,
        S_CR      = 4'd6,
        S_LB      = 4'd7,
        S_ERROR   = 4'd8
    } t_state;

    // Input beat register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // Parser state
    t_state r_state, n_state;
    logic   r_after_pair, n_after_pair;
    logic   r_subkey_mode, n_subkey_mode;

    // Result register
    logic      r_out_valid;
    logic [7:0] r_out_byte;
    t_out_user r_out_user;

    t_kind     n_kind;
    logic      n_key_start;
    logic [7:0] n_byte;
    t_out_user n_user;

    logic advance;
    logic is_crlf;

    // A beat moves to the result register whenever the result slot is free
    // or is being drained this cycle.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    assign is_crlf = (r_in_byte == CH_CR) || (r_in_byte == CH_LF);

    // Next-state and tag logic for the beat in the input register
    always_comb begin
        n_state       = r_state;
        n_after_pair  = r_after_pair;
        n_subkey_mode = r_subkey_mode;
        n_kind        = KIND_NONE;
        n_key_start   = 1'b0;
        n_byte        = r_in_byte;

        if (r_in_op == OP_EOS) begin
            // flush: report pending value or held error, then reset
            if (r_state == S_VALUE) begin
                n_kind = KIND_PAIR;
            end else if (r_state > S_LB) begin
                n_kind = KIND_ERROR;
            end
            n_byte        = 8'd0;
            n_state       = S_START;
            n_after_pair  = 1'b0;
            n_subkey_mode = 1'b0;
        end else begin
            unique case (r_state)
                S_START: begin
                    if (r_in_byte == CH_LF) begin
                        n_state = S_LB;
                    end else if (r_in_byte == CH_CR) begin
                        n_state = S_CR;
                    end else if (r_in_byte == CH_HASH) begin
                        n_state = S_COMMENT;
                    end else begin
                        // '=' or '.' leading the first line counts as key text
                        n_state     = S_KEY;
                        n_kind      = KIND_KEY;
                        n_key_start = 1'b1;
                    end
                end
                S_KEY: begin
                    if (r_in_byte == CH_EQUAL) begin
                        n_state = S_EQUAL;
                    end else if (is_crlf) begin
                        n_state = S_ERROR;
                        n_kind  = KIND_ERROR;
                    end else begin
                        n_kind = KIND_KEY;
                    end
                end
                S_SUBKEY: begin
                    // empty subkey is an error
                    if (is_crlf || r_in_byte == CH_EQUAL || r_in_byte == CH_DOT) begin
                        n_state = S_ERROR;
                        n_kind  = KIND_ERROR;
                    end else begin
                        n_state = S_KEY;
                        n_kind  = KIND_KEY;
                    end
                end
                S_EQUAL, S_VALUE: begin
                    if (is_crlf) begin
                        n_after_pair = 1'b1;
                        n_state      = (r_in_byte == CH_CR) ? S_CR : S_LB;
                        n_kind       = KIND_PAIR;
                    end else begin
                        n_state = S_VALUE;
                        n_kind  = KIND_VALUE;
                    end
                end
                S_COMMENT: begin
                    if (r_in_byte == CH_LF) begin
                        n_state = S_LB;
                    end else if (r_in_byte == CH_CR) begin
                        n_state = S_CR;
                    end
                end
                S_CR: begin
                    if (r_in_byte == CH_LF) begin
                        n_state = S_LB;
                    end else begin
                        // stray CR
                        n_state = S_ERROR;
                        n_kind  = KIND_ERROR;
                    end
                end
                S_LB: begin
                    if (r_in_byte == CH_LF) begin
                        n_after_pair = 1'b0;
                    end else if (r_in_byte == CH_CR) begin
                        n_after_pair = 1'b0;
                        n_state      = S_CR;
                    end else if (r_in_byte == CH_DOT) begin
                        if (r_after_pair) begin
                            n_subkey_mode = 1'b1;
                            n_state       = S_SUBKEY;
                            n_kind        = KIND_KEY;
                            n_key_start   = 1'b1;
                        end else begin
                            // dot line not following a pair line
                            n_state = S_ERROR;
                            n_kind  = KIND_ERROR;
                        end
                    end else if (r_in_byte == CH_HASH) begin
                        n_after_pair = 1'b0;
                        n_state      = S_COMMENT;
                    end else begin
                        n_after_pair  = 1'b0;
                        n_subkey_mode = 1'b0;
                        n_state       = S_KEY;
                        n_kind        = KIND_KEY;
                        n_key_start   = 1'b1;
                    end
                end
                default: begin
                    // error hold, and any unused encoding
                    n_state = S_ERROR;
                    n_kind  = KIND_ERROR;
                end
            endcase
        end

        n_user.kind      = n_kind;
        n_user.key_start = n_key_start;
        // subkey flag only on key, value and pair-end tags; end of stream
        // reports the mode that was in force before the flush
        n_user.subkey    = ((n_kind == KIND_KEY) || (n_kind == KIND_VALUE) ||
                            (n_kind == KIND_PAIR)) ?
                           ((r_in_op == OP_EOS) ? r_subkey_mode : n_subkey_mode) : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= S_START;
            r_after_pair  <= 1'b0;
            r_subkey_mode <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_state       <= n_state;
                r_after_pair  <= n_after_pair;
                r_subkey_mode <= n_subkey_mode;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out_byte <= n_byte;
            r_out_user <= n_user;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_user;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------

    // end of stream always leaves the parser in its reset state
    a_eos_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_EOS) |=>
            (r_state == S_START && !r_after_pair && !r_subkey_mode))
        else $error("parser state not cleared by end of stream");

    // error holds for every text byte
    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_BYTE && r_state == S_ERROR) |=>
            (r_state == S_ERROR && r_out_user.kind == KIND_ERROR))
        else $error("error state left without end of stream");

    // key start only on key tags
    a_kstart_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user.key_start) |-> (r_out_user.kind == KIND_KEY))
        else $error("key_start on a non-key tag");

    // subkey flag never on structural or error tags
    a_subkey_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user.subkey) |->
            (r_out_user.kind == KIND_KEY || r_out_user.kind == KIND_VALUE ||
             r_out_user.kind == KIND_PAIR))
        else $error("subkey flag on structural or error tag");

    // parser state only moves when a beat advances
    a_state_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("parser state changed without a beat");

endmodule

>>> dv/property_line_tokenizer_checker.sv
// ---------------------------------------------------------------------------
// property_line_tokenizer_checker: tag predictor and result comparator
// Watches both stream channels of the tokenizer, predicts the tag of every
// accepted input beat and compares it with the result beats in order.
// ---------------------------------------------------------------------------
module property_line_tokenizer_checker
    import plt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] in_byte
    input  logic                  i_s_axis_tuser,   // [0] op

    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [7:0]            i_m_axis_tdata,   // [7:0] out_byte
    input  logic [OUT_USER_W-1:0] i_m_axis_tuser,   // [2:0] kind, [3] key_start, [4] subkey

    output int                    o_fail_count,
    output int                    o_pending
);

    typedef enum logic [3:0] {
        PS_START,
        PS_KEY,
        PS_SUBKEY,
        PS_EQUAL,
        PS_VALUE,
        PS_COMMENT,
        PS_CR,
        PS_LB,
        PS_ERROR
    } t_parse;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       key_start;
        logic       subkey;
    } t_tag;

    t_parse pstate;
    logic   after_pair;
    logic   in_subkey;
    t_tag   tag_fifo[$];
    int     n_fail;
    int     n_seen;

    function automatic t_tag tag_next(input logic op, input logic [7:0] ch);
        t_tag t;
        t.kind      = KIND_NONE;
        t.data      = ch;
        t.key_start = 1'b0;
        t.subkey    = 1'b0;

        if (op == OP_EOS) begin
            if (pstate == PS_VALUE)
                t.kind = KIND_PAIR;
            else if (pstate == PS_ERROR)
                t.kind = KIND_ERROR;
            t.data   = 8'h00;
            t.subkey = (t.kind == KIND_PAIR) ? in_subkey : 1'b0;
            pstate     = PS_START;
            after_pair = 1'b0;
            in_subkey  = 1'b0;
            return t;
        end

        case (pstate)
            PS_START: begin
                if (ch == CH_LF) pstate = PS_LB;
                else if (ch == CH_CR) pstate = PS_CR;
                else if (ch == CH_HASH) pstate = PS_COMMENT;
                else begin
                    pstate = PS_KEY;
                    t.kind = KIND_KEY;
                    t.key_start = 1'b1;
                end
            end
            PS_KEY: begin
                if (ch == CH_EQUAL) pstate = PS_EQUAL;
                else if (ch == CH_CR || ch == CH_LF) begin
                    pstate = PS_ERROR;
                    t.kind = KIND_ERROR;
                end else
                    t.kind = KIND_KEY;
            end
            PS_SUBKEY: begin
                if (ch == CH_CR || ch == CH_LF || ch == CH_EQUAL || ch == CH_DOT) begin
                    pstate = PS_ERROR;
                    t.kind = KIND_ERROR;
                end else begin
                    pstate = PS_KEY;
                    t.kind = KIND_KEY;
                end
            end
            PS_EQUAL, PS_VALUE: begin
                if (ch == CH_CR || ch == CH_LF) begin
                    after_pair = 1'b1;
                    pstate = (ch == CH_CR) ? PS_CR : PS_LB;
                    t.kind = KIND_PAIR;
                end else begin
                    pstate = PS_VALUE;
                    t.kind = KIND_VALUE;
                end
            end
            PS_COMMENT: begin
                if (ch == CH_LF) pstate = PS_LB;
                else if (ch == CH_CR) pstate = PS_CR;
            end
            PS_CR: begin
                if (ch == CH_LF) pstate = PS_LB;
                else begin
                    pstate = PS_ERROR;
                    t.kind = KIND_ERROR;
                end
            end
            PS_LB: begin
                if (ch == CH_LF) begin
                    after_pair = 1'b0;
                end else if (ch == CH_CR) begin
                    after_pair = 1'b0;
                    pstate = PS_CR;
                end else if (ch == CH_DOT) begin
                    if (after_pair) begin
                        in_subkey = 1'b1;
                        pstate = PS_SUBKEY;
                        t.kind = KIND_KEY;
                        t.key_start = 1'b1;
                    end else begin
                        pstate = PS_ERROR;
                        t.kind = KIND_ERROR;
                    end
                end else if (ch == CH_HASH) begin
                    after_pair = 1'b0;
                    pstate = PS_COMMENT;
                end else begin
                    after_pair = 1'b0;
                    in_subkey  = 1'b0;
                    pstate = PS_KEY;
                    t.kind = KIND_KEY;
                    t.key_start = 1'b1;
                end
            end
            default: begin
                pstate = PS_ERROR;
                t.kind = KIND_ERROR;
            end
        endcase

        // subkey flag only rides on key, value and pair-end tags
        if (t.kind == KIND_KEY || t.kind == KIND_VALUE || t.kind == KIND_PAIR)
            t.subkey = in_subkey;
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_out_user got_user;
        t_tag      want;
        if (!i_rst_n) begin
            pstate     = PS_START;
            after_pair = 1'b0;
            in_subkey  = 1'b0;
            tag_fifo.delete();
            n_fail = 0;
            n_seen = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                tag_fifo.push_back(tag_next(i_s_axis_tuser, i_s_axis_tdata));

            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_user = i_m_axis_tuser;
                if (tag_fifo.size() == 0) begin
                    if (n_fail < 10)
                        $display("unexpected result beat %0d: kind %0d byte %02h",
                                 n_seen, got_user.kind, i_m_axis_tdata);
                    n_fail++;
                end else begin
                    want = tag_fifo.pop_front();
                    if (got_user.kind != want.kind || i_m_axis_tdata != want.data ||
                        got_user.key_start != want.key_start ||
                        got_user.subkey != want.subkey) begin
                        if (n_fail < 10) begin
                            $write("mismatch on result beat %0d: kind %0d/%0d ",
                                   n_seen, want.kind, got_user.kind);
                            $write("byte %02h/%02h key_start %0b/%0b ",
                                   want.data, i_m_axis_tdata,
                                   want.key_start, got_user.key_start);
                            $display("subkey %0b/%0b (expected/actual)",
                                     want.subkey, got_user.subkey);
                        end
                        n_fail++;
                    end
                end
                n_seen++;
            end
        end
        o_pending    = tag_fifo.size();
        o_fail_count = n_fail;
    end

endmodule

>>> dv/property_line_tokenizer_top_tb.sv
// ---------------------------------------------------------------------------
// property_line_tokenizer_top_tb: stream testbench for the properties tokenizer
// Feeds directed and randomly built properties text through the block with
// random idling on both sides; a checker beside the block predicts each tag.
// ---------------------------------------------------------------------------
module property_line_tokenizer_top_tb;
    import plt_pkg::*;

    localparam int N_RANDOM    = 700;        // random beats to send
    localparam int HOLD_AT     = 200;        // beats sent before the long output hold
    localparam int HOLD_CYCLES = 300;        // length of that hold
    localparam int DRAIN_WAIT  = 10;         // quiet cycles after the last result
    localparam int TIMEOUT     = 5_000_000;  // time units until the hard stop

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata;   // [7:0] in_byte
    logic                  i_s_axis_tuser;   // [0] op
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [7:0]            o_m_axis_tdata;   // [7:0] out_byte
    logic [OUT_USER_W-1:0] o_m_axis_tuser;   // [2:0] kind, [3] key_start, [4] subkey

    int n_fail;
    int n_pending;
    int n_sent;     // input beats accepted so far
    int tx_calm;    // beats left in a stretch sent back to back
    bit hold_done;

    property_line_tokenizer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    property_line_tokenizer_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_fail_count    (n_fail),
        .o_pending       (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or loses results.
    initial begin
        #(TIMEOUT);
        $display("simulation failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long gap.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // Any byte that does not break a line: value and comment text.
    function automatic logic [7:0] text_byte();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (ch == CH_CR || ch == CH_LF);
        return ch;
    endfunction

    // First byte of a plain key at line start: no line end, '#' or '.'.
    function automatic logic [7:0] key_head();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255));
        while (ch == CH_CR || ch == CH_LF || ch == CH_HASH || ch == CH_DOT);
        return ch;
    endfunction

    // Key byte after the first: anything but a line end or '='.
    function automatic logic [7:0] key_body();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255));
        while (ch == CH_CR || ch == CH_LF || ch == CH_EQUAL);
        return ch;
    endfunction

    // Byte biased toward the characters the parser reacts to.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return CH_EQUAL;
            1: return CH_HASH;
            2: return CH_DOT;
            3: return CH_CR;
            4: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One input beat: hold it until accepted, then maybe idle. valid is
    // only dropped when a gap follows, so back-to-back beats never see a
    // low/high pair of assignments in one step.
    task automatic offer(input logic op, input logic [7:0] ch);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else
            gap = idle_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input logic [7:0] ch);
        offer(OP_BYTE, ch);
    endtask

    // End-of-stream beat; tdata is don't-care, so keep it random.
    task automatic send_eos();
        offer(OP_EOS, 8'($urandom_range(0, 255)));
    endtask

    // LF or CR LF
    task automatic send_eol();
        if ($urandom_range(0, 2) == 0)
            send_text(CH_CR);
        send_text(CH_LF);
    endtask

    // key=value without the line end; a subkey line is led by '.'
    task automatic send_pair(input bit sub);
        int n;
        logic [7:0] ch;
        if (sub) begin
            send_text(CH_DOT);
            do ch = key_body(); while (ch == CH_DOT);
            send_text(ch);
        end else
            send_text(key_head());
        n = $urandom_range(0, 5);
        repeat (n) send_text(key_body());
        send_text(CH_EQUAL);
        n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) send_text(text_byte());
    endtask

    // Receiver: random stalls, calm stretches, and one long hold while the
    // sender keeps going, so both pipeline registers fill and tready drops.
    initial begin : rx_side
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        hold_done = 1'b0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_sent >= HOLD_AT) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                i_m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 4) begin
                calm = $urandom_range(20, 100);
                i_m_axis_tready <= 1'b1;
            end else begin
                stall = idle_len();
                if (stall == 0)
                    i_m_axis_tready <= 1'b1;
                else begin
                    stall--;
                    i_m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // Sender: reset, directed text, then random properties text.
    initial begin : tx_side
        int r;
        int n;
        int stop_at;
        n_sent  = 0;
        tx_calm = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_s_axis_tuser  <= OP_BYTE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // leading '=' on the first line is a key byte; extreme bytes in key and value
        send_text(CH_EQUAL); send_text(8'h00); send_text(CH_EQUAL);
        send_text(8'hFF); send_text(CH_LF);
        // subkey line after a pair line, empty value closed by CR LF
        send_text(CH_DOT); send_text(8'h80); send_text(CH_EQUAL);
        send_text(CH_CR); send_text(CH_LF);
        // empty subkey, error held into end of stream
        send_text(CH_DOT); send_text(CH_EQUAL); send_eos();
        // comment then a stray CR
        send_text(CH_HASH); send_text(CH_CR); send_text(8'h5A); send_eos();
        // '.' leading a line that is not after a pair line
        send_text(CH_LF); send_text(CH_DOT); send_eos();
        // line break inside a key
        send_text(8'h7F); send_text(CH_CR); send_eos();
        // end of stream with a value pending, then on an idle parser
        send_text(8'h01); send_text(CH_EQUAL); send_text(8'hFE); send_eos();
        send_eos();
        // key and '=' but no value: dropped at end of stream
        send_text(8'h41); send_text(CH_EQUAL); send_eos();

        // Mostly well-formed lines with random content; broken lines always end
        // with an end-of-stream beat and noise usually does, often enough that the
        // sticky error state does not swallow the rest.
        stop_at = n_sent + N_RANDOM;
        while (n_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                tx_calm = $urandom_range(10, 40);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_pair(1'b0);
                send_eol();
                while ($urandom_range(0, 1) == 1) begin
                    send_pair(1'b1);
                    send_eol();
                end
            end else if (r < 60) begin
                send_text(CH_HASH);
                n = $urandom_range(0, 8);
                repeat (n) send_text(text_byte());
                send_eol();
            end else if (r < 65) begin
                send_eol();
            end else if (r < 72) begin
                // stream ends mid-line, value pending or not
                send_pair(1'($urandom_range(0, 1)));
                send_eos();
            end else if (r < 77) begin
                send_eos();
            end else if (r < 87) begin
                n = $urandom_range(1, 6);
                repeat (n) send_text(noise_byte());
                if ($urandom_range(0, 4) != 0)
                    send_eos();
            end else begin
                case ($urandom_range(0, 3))
                    0: begin  // stray CR
                        send_text(CH_CR);
                        send_text(key_body() == CH_LF ? 8'h20 : key_body());
                    end
                    1: begin  // '.' on a line not after a pair line
                        send_text(CH_LF);
                        send_text(CH_DOT);
                    end
                    2: begin  // empty subkey
                        send_pair(1'b0);
                        send_eol();
                        send_text(CH_DOT);
                        case ($urandom_range(0, 3))
                            0: send_text(CH_CR);
                            1: send_text(CH_LF);
                            2: send_text(CH_EQUAL);
                            default: send_text(CH_DOT);
                        endcase
                    end
                    default: begin  // line break inside a key
                        send_text(key_head());
                        send_text($urandom_range(0, 1) ? CH_CR : CH_LF);
                    end
                endcase
                send_eos();
            end
        end

        if (i_s_axis_tvalid)
            i_s_axis_tvalid <= 1'b0;

        // drain: all predicted tags delivered, then a few quiet cycles to
        // catch any extra result beat
        @(negedge i_clk);
        while (n_pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
